[design/lqt_pkg.sv]
`timescale 1ns / 1ps
package lqt_pkg;

   typedef enum logic [1:0] {
      ACT_ADD    = 2'd0,
      ACT_FIND   = 2'd1,
      ACT_REMOVE = 2'd2,
      ACT_READ   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_MISS = 2'd2
   } status_type;

   typedef struct packed {
      logic [15:0]        local_addr;
      logic [15:0]        remote_addr;
      logic signed [7:0]  snr;
      logic [31:0]        refresh_time;
   } entry_type;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_SCAN = 5'b00010,
      S_LAST = 5'b00100,
      S_IDX  = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   localparam int EXT_WIDTH = 6;

endpackage

[design/lqt_if.sv]
`timescale 1ns / 1ps
interface lqt_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         action;
   logic [15:0]        local_addr;
   logic [15:0]        remote_addr;
   logic signed [7:0]  snr_in;
   logic [31:0]        now_ms;
   logic [5:0]         entry_index;

   modport source (output valid, action, local_addr, remote_addr, snr_in, now_ms,
                   entry_index, input ready);
   modport sink (input valid, action, local_addr, remote_addr, snr_in, now_ms,
                 entry_index, output ready);
endinterface

interface lqt_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic [15:0]        out_local;
   logic [15:0]        out_remote;
   logic signed [7:0]  out_snr;
   logic [31:0]        out_refresh_time;
   logic [5:0]         entry_count;

   modport source (output valid, status, out_local, out_remote, out_snr,
                   out_refresh_time, entry_count, input ready);
   modport sink (input valid, status, out_local, out_remote, out_snr,
                 out_refresh_time, entry_count, output ready);
endinterface

[design/lqt_mem.sv]
`timescale 1ns / 1ps
module lqt_mem #(
   parameter int Depth     = 32,
   parameter int AddrWidth = 5
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AddrWidth-1:0]  wr_addr,
   input  lqt_pkg::entry_type    wr_data,
   input  logic                  rd_en,
   input  logic [AddrWidth-1:0]  rd_addr,
   output lqt_pkg::entry_type    rd_data
);
   import lqt_pkg::*;

   entry_type mem_ff [Depth];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/link_quality_table.sv]
`timescale 1ns / 1ps
// Add, find and remove scan slots 0..count-1 through the table RAM, one read per
// cycle with each compare in the cycle after its read. The result is registered
// and sent from S_DONE, which waits while an earlier response is not yet taken.
// A remove that hits fetches the last entry and moves it into the freed slot.
// Index reads go via S_IDX, or to S_DONE if out of range. One item at a time.
// Synchronous reset clears the entry count and control; RAM contents are kept.
module link_quality_table #(
   parameter int CAPACITY = 32
) (
   input  logic       clock,
   input  logic       reset,
   lqt_req_if.sink    req_chan,
   lqt_rsp_if.source  rsp_chan
);
   import lqt_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = (CW > EXT_WIDTH) ? CW : EXT_WIDTH;

   state_type          state_ff, state_in;
   logic [1:0]         action_ff, action_in;
   logic [15:0]        local_ff, local_in;
   logic [15:0]        remote_ff, remote_in;
   logic signed [7:0]  snr_ff, snr_in;
   logic [31:0]        now_ff, now_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      scan_ff, scan_in;
   logic               pend_ff, pend_in;
   logic [AW-1:0]      pend_idx_ff, pend_idx_in;
   logic [AW-1:0]      slot_ff, slot_in;
   status_type         res_status_ff, res_status_in;
   entry_type          res_entry_ff, res_entry_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   entry_type          rsp_entry_ff, rsp_entry_in;
   logic [5:0]         rsp_count_ff, rsp_count_in;

   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr;
   entry_type          mem_wr_data;
   logic               mem_rd_en;
   logic [AW-1:0]      mem_rd_addr;
   entry_type          mem_rd_data;

   logic [IW-1:0]      idx_ext;
   logic [IW-1:0]      count_ext;
   logic [CW-1:0]      last_idx;
   logic               key_match;
   logic               hit;

   lqt_mem #(
      .Depth     (CAPACITY),
      .AddrWidth (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign idx_ext   = IW'(req_chan.entry_index);
   assign count_ext = IW'(count_ff);
   assign last_idx  = count_ff - CW'(1);
   assign key_match = (mem_rd_data.local_addr == local_ff) &&
                      (mem_rd_data.remote_addr == remote_ff);
   assign hit       = pend_ff && key_match;

   always_comb begin
      state_in      = state_ff;
      action_in     = action_ff;
      local_in      = local_ff;
      remote_in     = remote_ff;
      snr_in        = snr_ff;
      now_in        = now_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      slot_in       = slot_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_count_in  = rsp_count_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = pend_idx_ff;
      mem_wr_data   = '{local_addr: local_ff, remote_addr: remote_ff,
                        snr: snr_ff, refresh_time: now_ff};
      mem_rd_en     = 1'b0;
      mem_rd_addr   = scan_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               action_in = req_chan.action;
               local_in  = req_chan.local_addr;
               remote_in = req_chan.remote_addr;
               snr_in    = req_chan.snr_in;
               now_in    = req_chan.now_ms;
               scan_in   = '0;
               pend_in   = 1'b0;
               if (action_type'(req_chan.action) == ACT_READ) begin
                  if (idx_ext < count_ext) begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = idx_ext[AW-1:0];
                     state_in    = S_IDX;
                  end else begin
                     res_status_in = ST_MISS;
                     res_entry_in  = '0;
                     state_in      = S_DONE;
                  end
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (hit) begin
               res_status_in = ST_OK;
               res_entry_in  = '0;
               state_in      = S_DONE;
               case (action_type'(action_ff))
                  ACT_ADD: begin
                     mem_wr_en = 1'b1;
                  end
                  ACT_FIND: begin
                     res_entry_in = mem_rd_data;
                  end
                  ACT_REMOVE: begin
                     // fetch the tail entry to fill the freed slot
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = last_idx[AW-1:0];
                     slot_in     = pend_idx_ff;
                     state_in    = S_LAST;
                  end
                  default: begin
                     res_status_in = ST_MISS;
                  end
               endcase
            end else if (scan_ff < count_ff) begin
               mem_rd_en   = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = scan_ff[AW-1:0];
               scan_in     = scan_ff + CW'(1);
            end else if (pend_ff) begin
               // last compare missed; clear the pending compare before finishing
               pend_in = 1'b0;
            end else begin
               res_entry_in  = '0;
               res_status_in = ST_MISS;
               state_in      = S_DONE;
               if (action_type'(action_ff) == ACT_ADD) begin
                  if (count_ff < CW'(CAPACITY)) begin
                     mem_wr_en     = 1'b1;
                     mem_wr_addr   = count_ff[AW-1:0];
                     count_in      = count_ff + CW'(1);
                     res_status_in = ST_OK;
                  end else begin
                     res_status_in = ST_FULL;
                  end
               end
            end
         end
         S_LAST: begin
            mem_wr_en     = 1'b1;
            mem_wr_addr   = slot_ff;
            mem_wr_data   = mem_rd_data;
            count_in      = last_idx;
            res_status_in = ST_OK;
            res_entry_in  = '0;
            state_in      = S_DONE;
         end
         S_IDX: begin
            res_status_in = ST_OK;
            res_entry_in  = mem_rd_data;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_entry_in  = res_entry_ff;
               rsp_count_in  = count_ext[5:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff     <= action_in;
      local_ff      <= local_in;
      remote_ff     <= remote_in;
      snr_ff        <= snr_in;
      now_ff        <= now_in;
      scan_ff       <= scan_in;
      pend_idx_ff   <= pend_idx_in;
      slot_ff       <= slot_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_chan.ready            = (state_ff == S_IDLE);
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = rsp_status_ff;
   assign rsp_chan.out_local        = rsp_entry_ff.local_addr;
   assign rsp_chan.out_remote       = rsp_entry_ff.remote_addr;
   assign rsp_chan.out_snr          = rsp_entry_ff.snr;
   assign rsp_chan.out_refresh_time = rsp_entry_ff.refresh_time;
   assign rsp_chan.entry_count      = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |->
         ((count_ff == $past(count_ff) + CW'(1)) ||
          (count_ff == $past(count_ff) - CW'(1))))
      else $error("entry count moved by more than one");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> (state_ff != S_IDLE))
      else $error("accepted beat did not start an operation");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> ((state_ff == S_SCAN) || (state_ff == S_LAST)))
      else $error("table write outside scan or tail move");

endmodule
